### rtl/b64d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64url decoder
// Holds the character decode function, the status codes and the layout of
// one result transfer.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // End-of-text status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR  = 2'd1;
    localparam logic [1:0] STATUS_LEFTOVER  = 2'd2;

    // Pad character that stops decoding.
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // One result transfer.
    typedef struct packed {
        logic [1:0] status;
        logic       end_of_text;
        logic       byte_present;
        logic [7:0] out_byte;
    } result_t;

    // Character decode: bit 6 is the valid flag, bits 5:0 the sextet value.
    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            s.value = 6'(ch - 8'h41);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            s.value = 6'(ch - 8'h61 + 8'd26);
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            s.value = 6'(ch - 8'h30 + 8'd52);
        end else if (ch == 8'h2D) begin
            s.value = 6'd62;
        end else if (ch == 8'h5F) begin
            s.value = 6'd63;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

### rtl/base64url_strict_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64url_strict_decoder_core: streaming base64url text to byte decoder
// Decodes one character per transfer and streams out each byte as it forms.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while the skid register is empty,
// and each one is decoded in the cycle it is accepted: a table lookup and a
// short shift update the residue state, and any result goes into a two-entry
// output stage (output register plus skid register), so input acceptance
// keeps going while a result waits. Each result is registered there. A
// result is sent for every completed byte and for the character marked with
// s_tlast; that final transfer carries m_tlast and the status in m_tuser
// (ok, invalid character, nonzero leftover bits). An invalid character
// voids the whole text through that final status only; bytes already sent
// are not recalled. After '=' or an invalid character the remaining
// characters of the text are ignored. The state clears after each text.
// ----------------------------------------------------------------------------
module base64url_strict_decoder_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Input channel.
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_in
    input  wire logic       s_tlast,   // last
    // Result channel.
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,   // [7:0] out_byte
    output      logic [2:0] m_tuser,   // [0] byte_present, [2:1] status
    output      logic       m_tlast    // end_of_text
);
    import b64d_pkg::*;

    // Decoder state.
    logic [5:0] residue_reg, residue_next;
    logic [2:0] pending_reg, pending_next;
    logic       pad_seen_reg, pad_seen_next;
    logic       error_seen_reg, error_seen_next;

    // Output stage.
    result_t    out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    result_t    skid_reg, skid_next;
    logic       skid_valid_reg, skid_valid_next;

    logic       in_xfer;
    logic       produce;
    result_t    res;
    sextet_t    sx;
    logic [11:0] combined;
    logic [3:0]  nbits;
    logic [6:0]  keep_mask;
    logic [11:0] shifted;
    logic        have_byte;
    logic [5:0]  upd_residue;
    logic [2:0]  upd_pending;
    logic        upd_pad;
    logic        upd_error;

    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;

    // Character decode and residue update.
    always_comb begin
        sx          = sextet_of(s_tdata);
        combined    = {residue_reg, sx.value};
        nbits       = {1'b0, pending_reg} + 4'd6;
        have_byte   = 1'b0;
        shifted     = combined;
        upd_residue = residue_reg;
        upd_pending = pending_reg;
        upd_pad     = pad_seen_reg;
        upd_error   = error_seen_reg;
        keep_mask   = 7'd0;
        if (!pad_seen_reg && !error_seen_reg) begin
            if (s_tdata == PAD_CHAR) begin
                upd_pad = 1'b1;
            end else if (!sx.valid) begin
                upd_error = 1'b1;
            end else begin
                if (nbits >= 4'd8) begin
                    have_byte   = 1'b1;
                    upd_pending = 3'(nbits - 4'd8);
                    shifted     = combined >> upd_pending;
                end else begin
                    upd_pending = nbits[2:0];
                end
                keep_mask   = (7'd1 << upd_pending) - 7'd1;
                upd_residue = combined[5:0] & keep_mask[5:0];
            end
        end
    end

    // Result assembly and state for the next character.
    always_comb begin
        res.out_byte     = have_byte ? shifted[7:0] : 8'd0;
        res.byte_present = have_byte;
        res.end_of_text  = s_tlast;
        res.status       = STATUS_OK;
        if (s_tlast) begin
            if (upd_error) begin
                res.status = STATUS_BAD_CHAR;
            end else if (upd_pending != 3'd0 && upd_residue != 6'd0) begin
                res.status = STATUS_LEFTOVER;
            end
        end
        produce = in_xfer && (have_byte || s_tlast);

        residue_next    = residue_reg;
        pending_next    = pending_reg;
        pad_seen_next   = pad_seen_reg;
        error_seen_next = error_seen_reg;
        if (in_xfer) begin
            if (s_tlast) begin
                residue_next    = 6'd0;
                pending_next    = 3'd0;
                pad_seen_next   = 1'b0;
                error_seen_next = 1'b0;
            end else begin
                residue_next    = upd_residue;
                pending_next    = upd_pending;
                pad_seen_next   = upd_pad;
                error_seen_next = upd_error;
            end
        end
    end

    // Output register with skid register behind it.
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = res;
                skid_valid_next = produce;
            end else begin
                out_next        = res;
                out_valid_next  = produce;
            end
        end else if (produce) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            residue_reg    <= 6'd0;
            pending_reg    <= 3'd0;
            pad_seen_reg   <= 1'b0;
            error_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            residue_reg    <= residue_next;
            pending_reg    <= pending_next;
            pad_seen_reg   <= pad_seen_next;
            error_seen_reg <= error_seen_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tuser  = {out_reg.status, out_reg.byte_present};
    assign m_tlast  = out_reg.end_of_text;

endmodule
`default_nettype wire

### rtl/b64d_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_checker: port-level checks for the base64url decoder
// Watches the result channel for consistency of the status and byte flags.
// ----------------------------------------------------------------------------
module b64d_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [2:0] m_tuser,
    input wire logic       m_tlast
);
    import b64d_pkg::*;

    // A status is reported only on the final transfer of a text.
    a_status_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[2:1] == STATUS_OK)
        else $error("status reported on a transfer that does not end the text");

    // Every transfer except the final one carries a byte.
    a_mid_carries_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[0])
        else $error("result transfer without a byte before end of text");

    // Transfers without a byte carry a zero data field.
    a_empty_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("nonzero data on a transfer without a byte");

    // The status code is always one of the three defined codes.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[2:1] == STATUS_OK || m_tuser[2:1] == STATUS_BAD_CHAR ||
                      m_tuser[2:1] == STATUS_LEFTOVER))
        else $error("undefined status code");

    // A stalled result transfer holds its contents.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

endmodule

bind base64url_strict_decoder_core b64d_checker u_b64d_checker (.*);
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the base64url streaming decoder
// Feeds base64url texts one character per transfer, predicts every decoded
// byte and end-of-text status in the bench, and compares each result transfer
// field by field. Both channels stall at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    import b64d_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SHOW_MAX      = 10;
    localparam int IDLE_PERCENT  = 37;
    localparam int TAIL_CYCLES   = 6;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    // Characters waiting to be sent and decoded results waiting to arrive.
    text_char_t char_queue[$];
    result_t    decoded_queue[$];

    // Decoder state as the bench tracks it.
    int   held_value;
    int   held_bits;
    bit   pad_hit;
    bit   bad_hit;

    bit   steady = 1'b0;
    int   errors;
    int   cycles;
    int   chars_queued;
    int   bytes_checked;
    int   texts_by_status[3];

    base64url_strict_decoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Six-bit value of a text character, or -1 outside the alphabet.
    function automatic int sextet_value(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z") return int'(ch) - 65;
        if (ch >= "a" && ch <= "z") return int'(ch) - 97 + 26;
        if (ch >= "0" && ch <= "9") return int'(ch) - 48 + 52;
        if (ch == "-") return 62;
        if (ch == "_") return 63;
        return -1;
    endfunction

    // Alphabet character that carries a given six-bit value.
    function automatic logic [7:0] alphabet_char(input int v);
        if (v < 26) return 8'(65 + v);
        if (v < 52) return 8'(97 + v - 26);
        if (v < 62) return 8'(48 + v - 52);
        return (v == 62) ? 8'h2D : 8'h5F;
    endfunction

    // Any byte that is neither in the alphabet nor the pad character.
    function automatic logic [7:0] stray_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (sextet_value(c) >= 0 || c == PAD_CHAR) c = 8'($urandom_range(255));
        return c;
    endfunction

    // Track one accepted character and record the result it must produce.
    function automatic void decode_char(input logic [7:0] ch, input logic last);
        result_t r;
        int      v;
        int      joined;
        int      nbits;
        r = '0;
        if (!pad_hit && !bad_hit) begin
            if (ch == PAD_CHAR) begin
                pad_hit = 1'b1;
            end else begin
                v = sextet_value(ch);
                if (v < 0) begin
                    bad_hit = 1'b1;
                end else begin
                    joined = (held_value << 6) | v;
                    nbits  = held_bits + 6;
                    if (nbits >= 8) begin
                        nbits          = nbits - 8;
                        r.out_byte     = 8'(joined >> nbits);
                        r.byte_present = 1'b1;
                    end
                    held_bits  = nbits;
                    held_value = joined & ((1 << nbits) - 1);
                end
            end
        end
        if (!r.byte_present && !last) return;
        if (last) begin
            r.end_of_text = 1'b1;
            if (bad_hit) r.status = STATUS_BAD_CHAR;
            else if (held_bits != 0 && held_value != 0) r.status = STATUS_LEFTOVER;
            else r.status = STATUS_OK;
            texts_by_status[r.status]++;
            held_value = 0;
            held_bits  = 0;
            pad_hit    = 1'b0;
            bad_hit    = 1'b0;
        end
        decoded_queue.insert(decoded_queue.size(), r);
    endfunction

    task automatic add_char(input logic [7:0] ch, input logic last);
        text_char_t t;
        t.ch   = ch;
        t.last = last;
        char_queue.insert(char_queue.size(), t);
        chars_queued++;
    endtask

    task automatic add_string(input string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
    endtask

    // One random text: mostly well-formed, some with a stray character, some noise.
    task automatic add_random_text();
        int            kind;
        int            len;
        int            bad_at;
        int            tail;
        logic [7:0]    body[$];
        kind = $urandom_range(99);
        len  = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            if (kind >= 80) body.insert(body.size(), 8'($urandom_range(255)));
            else body.insert(body.size(), alphabet_char($urandom_range(63)));
        end
        if (kind < 60) begin
            // Optional padding, sometimes followed by junk that must be ignored.
            if ($urandom_range(1)) begin
                while (body.size() % 4 != 0) body.insert(body.size(), PAD_CHAR);
            end else if ($urandom_range(3) == 0) begin
                body.insert(body.size(), PAD_CHAR);
            end
            if (body[body.size() - 1] == PAD_CHAR && $urandom_range(2) == 0) begin
                tail = $urandom_range(1, 4);
                for (int i = 0; i < tail; i++)
                    body.insert(body.size(), 8'($urandom_range(255)));
            end
        end else if (kind < 80) begin
            bad_at = $urandom_range(len - 1);
            body[bad_at] = stray_char();
        end
        foreach (body[i]) add_char(body[i], i == body.size() - 1);
    endtask

    task automatic add_random_until(input int target);
        while (chars_queued < target) add_random_text();
    endtask

    // Hold the sender until every queued character has been sent and decoded.
    // The check runs on the falling edge, once the rising-edge updates settled.
    task automatic wait_drained();
        while (char_queue.size() != 0 || s_tvalid || decoded_queue.size() != 0)
            @(negedge aclk);
    endtask

    // Character source: presents queued characters with random gaps.
    always @(posedge aclk) begin
        text_char_t t;
        bit         took;
        took = s_tvalid && s_tready;
        if (took) decode_char(s_tdata, s_tlast);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || took) begin
            if (char_queue.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                t = char_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= t.ch;
                s_tlast  <= t.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: checks every result transfer against the oldest prediction.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser[2:1], m_tlast, m_tuser[0], m_tdata};
                if (decoded_queue.size() == 0) begin
                    errors++;
                    if (errors <= SHOW_MAX)
                        $display({"ERROR: unexpected result: byte %02h present %0d ",
                                  "end %0d status %0d"},
                                 got.out_byte, got.byte_present, got.end_of_text,
                                 got.status);
                end else begin
                    want = decoded_queue.pop_front();
                    if (want.byte_present) bytes_checked++;
                    if (got.out_byte !== want.out_byte ||
                        got.byte_present !== want.byte_present ||
                        got.end_of_text !== want.end_of_text ||
                        got.status !== want.status) begin
                        errors++;
                        if (errors <= SHOW_MAX)
                            $display({"ERROR: result mismatch: byte %02h/%02h present %0d/%0d ",
                                      "end %0d/%0d status %0d/%0d (expected/actual)"},
                                     want.out_byte, got.out_byte, want.byte_present,
                                     got.byte_present, want.end_of_text, got.end_of_text,
                                     want.status, got.status);
                    end
                end
            end
            m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ERROR: run timed out after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed texts: every alphabet range, both byte extremes, padding with and
        // without leftover bits, a stray character alone and before the end,
        // error taking priority over leftover bits, a byte on the final
        // character, and a lone pad character.
        add_string("AZaz09-_");
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b1);
        add_string("/");
        add_string("QQ==");
        add_string("QR=");
        add_char("B", 1'b0);
        add_char(8'h80, 1'b1);
        add_string("QQ");
        add_string("=");
        add_char("A", 1'b0);
        add_char(8'hFF, 1'b0);
        add_char("g", 1'b1);

        add_random_until(350);
        wait_drained();

        // Full-rate stretch on both channels.
        steady = 1'b1;
        add_random_until(600);
        wait_drained();
        steady = 1'b0;

        add_random_until(950);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (decoded_queue.size() != 0) begin
            errors++;
            $display("ERROR: %0d predicted results never arrived", decoded_queue.size());
        end
        $display({"Sent %0d characters; %0d texts ended ok, %0d with a stray character, ",
                  "%0d with leftover bits."},
                 chars_queued, texts_by_status[STATUS_OK], texts_by_status[STATUS_BAD_CHAR],
                 texts_by_status[STATUS_LEFTOVER]);
        $display("Checked %0d decoded bytes in %0d cycles; %0d mismatches.",
                 bytes_checked, cycles, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### base64url_strict_decoder_core.f
rtl/b64d_pkg.sv
rtl/base64url_strict_decoder_core.sv
rtl/b64d_checker.sv
tb/tb_top.sv
